@@ rtl/ole_pkg.sv @@
package ole_pkg;

  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_END   = 3'd1;
  localparam logic [2:0] FUNC_INS_AT    = 3'd2;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd3;
  localparam logic [2:0] FUNC_DEL_END   = 3'd4;
  localparam logic [2:0] FUNC_DEL_AT    = 3'd5;
  localparam logic [2:0] FUNC_SEARCH    = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 32;

  // Datapath operations issued by the controller, one per cycle.
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_INIT      = 4'd1;  // chain one entry onto the free list
  localparam logic [3:0] OP_LATCH     = 4'd2;  // capture the request
  localparam logic [3:0] OP_START     = 4'd3;  // cursor to head, read it
  localparam logic [3:0] OP_STEP      = 4'd4;  // cursor follows next link
  localparam logic [3:0] OP_SET_CUR   = 4'd5;  // cursor to sel index, read it
  localparam logic [3:0] OP_INS       = 4'd6;  // link free entry after anchor
  localparam logic [3:0] OP_INS_FIX   = 4'd7;  // set back link of follower
  localparam logic [3:0] OP_DEL       = 4'd8;  // read neighbors of cursor
  localparam logic [3:0] OP_DEL_FIX1  = 4'd9;  // forward link of predecessor
  localparam logic [3:0] OP_DEL_FIX2  = 4'd10; // back link of successor
  localparam logic [3:0] OP_FREE_RD   = 4'd11; // read head of free list

  typedef struct packed {
    logic [3:0] op;
    logic       anchor_tail;   // OP_INS: anchor is tail, else cursor
    logic       anchor_nil;    // OP_INS: insert at front
    logic       sel_tail;      // OP_SET_CUR: tail, else head
  } ole_cmd_t;

  typedef struct packed {
    logic       cur_nil;       // cursor is null
    logic       match;         // cursor value equals request value
    logic       init_done;
  } ole_stat_t;

endpackage

@@ rtl/ole_datapath.sv @@
module ole_datapath #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ole_pkg::ole_cmd_t            cmd,
  input  logic [ole_pkg::OUT_W-1:0]    req_value,
  output ole_pkg::ole_stat_t           stat,
  output logic [ole_pkg::OUT_W-1:0]    removed_value
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [IW-1:0]          next_mem  [CAPACITY];
  logic [IW-1:0]          prev_mem  [CAPACITY];

  logic [IW-1:0] head_index, tail_index, free_head, cursor, pred, succ;
  logic [IW-1:0] init_idx, ins_new, ins_after;
  logic [VALUE_WIDTH-1:0] val, cur_value;
  logic [IW-1:0] cur_next;

  // Insert anchor and the entry that follows it; the cursor's next link is
  // only valid right after a read of the cursor, so the anchor's follower is
  // captured when the controller reads the free head (OP_FREE_RD keeps a copy).
  logic [IW-1:0] ins_anchor, anchor_after, anchor_next_q;

  function automatic logic [ole_pkg::OUT_W-1:0] OUT_EXT(input logic [VALUE_WIDTH-1:0] v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = v;
    return ole_pkg::OUT_W'(s);
  endfunction

  // Registered read ports of the three memories, addressed by the index each op reads.
  logic [IW-1:0] rd_idx;
  always_comb begin
    rd_idx = cursor;
    case (cmd.op)
      ole_pkg::OP_START:   rd_idx = head_index;
      ole_pkg::OP_STEP:    rd_idx = cur_next;
      ole_pkg::OP_SET_CUR: rd_idx = cmd.sel_tail ? tail_index : head_index;
      ole_pkg::OP_FREE_RD: rd_idx = free_head;
      default:             rd_idx = cursor;
    endcase
  end

  logic [IW-1:0] rd_prev;
  always_ff @(posedge clk) begin
    if (rd_idx < NIL) begin
      cur_value <= value_mem[rd_idx[AW-1:0]];
      cur_next  <= next_mem[rd_idx[AW-1:0]];
      rd_prev   <= prev_mem[rd_idx[AW-1:0]];
    end else begin
      cur_value <= '0;
      cur_next  <= NIL;
      rd_prev   <= NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= NIL;
      tail_index <= NIL;
      free_head  <= '0;
      init_idx   <= '0;
      cursor     <= NIL;
    end else begin
      case (cmd.op)
        ole_pkg::OP_INIT: begin
          if (init_idx < NIL) begin
            next_mem[init_idx[AW-1:0]] <= init_idx + IW'(1);
            init_idx <= init_idx + IW'(1);
          end
        end
        ole_pkg::OP_LATCH: val <= req_value[VALUE_WIDTH-1:0];
        ole_pkg::OP_START: cursor <= head_index;
        ole_pkg::OP_STEP: cursor <= cur_next;
        ole_pkg::OP_SET_CUR: cursor <= cmd.sel_tail ? tail_index : head_index;
        ole_pkg::OP_INS: begin
          // cur_next holds the next link of the free head (read by OP_FREE_RD).
          free_head <= cur_next;
          value_mem[ins_new[AW-1:0]] <= val;
          prev_mem[ins_new[AW-1:0]]  <= ins_anchor;
          next_mem[ins_new[AW-1:0]]  <= anchor_after;
          if (ins_anchor < NIL) next_mem[ins_anchor[AW-1:0]] <= ins_new;
          else head_index <= ins_new;
          ins_after <= anchor_after;
        end
        ole_pkg::OP_INS_FIX: begin
          if (ins_after < NIL) prev_mem[ins_after[AW-1:0]] <= ins_new;
          else tail_index <= ins_new;
        end
        ole_pkg::OP_DEL: begin
          pred <= rd_prev;
          succ <= cur_next;
          removed_value <= OUT_EXT(cur_value);
          next_mem[cursor[AW-1:0]] <= free_head;
          free_head <= cursor;
        end
        ole_pkg::OP_DEL_FIX1: begin
          if (pred < NIL) next_mem[pred[AW-1:0]] <= succ;
          else head_index <= succ;
        end
        ole_pkg::OP_DEL_FIX2: begin
          if (succ < NIL) prev_mem[succ[AW-1:0]] <= pred;
          else tail_index <= pred;
        end
        default: ;
      endcase
      if (cmd.op == ole_pkg::OP_LATCH) removed_value <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ole_pkg::OP_FREE_RD) begin
      ins_new <= free_head;
      anchor_next_q <= cur_next;
    end
  end
  assign ins_anchor   = cmd.anchor_nil ? NIL : (cmd.anchor_tail ? tail_index : cursor);
  assign anchor_after = cmd.anchor_nil ? head_index
                      : (cmd.anchor_tail ? NIL : anchor_next_q);

  assign stat.cur_nil   = (cursor >= NIL);
  assign stat.match     = (cur_value == val);
  assign stat.init_done = (init_idx >= NIL);

endmodule

@@ rtl/ole_ctrl.sv @@
module ole_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ole_pkg::FUNC_W-1:0]    func,
  input  logic [ole_pkg::POS_W-1:0]     position,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ole_pkg::STAT_W-1:0]    status,
  output logic [ole_pkg::POS_W-1:0]     found_position,
  output logic [ole_pkg::POS_W-1:0]     entry_count,
  output ole_pkg::ole_cmd_t             cmd,
  input  ole_pkg::ole_stat_t            stat
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_SRCH   = 4'd4;
  localparam logic [3:0] S_FREE   = 4'd5;
  localparam logic [3:0] S_INS    = 4'd6;
  localparam logic [3:0] S_INSFIX = 4'd7;
  localparam logic [3:0] S_DEL    = 4'd8;
  localparam logic [3:0] S_DFIX1  = 4'd9;
  localparam logic [3:0] S_DFIX2  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;
  localparam logic [3:0] S_RDCUR  = 4'd12;

  logic [3:0] state, state_next;
  logic [2:0] fn;
  logic [ole_pkg::POS_W-1:0] pos;
  logic [CW-1:0] count, steps;
  logic [1:0] anchor;   // 0 cursor, 1 tail, 2 front

  // A new item is taken only once the previous result has left, so the
  // result fields stay put while m_tvalid is high.
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_INIT: if (stat.init_done) state <= S_IDLE;
        S_IDLE: if (s_tvalid && s_tready) begin
          fn <= func;
          pos <= position;
          status <= ole_pkg::ST_OK;
          found_position <= '0;
          steps <= CW'(1);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_DONE;
          case (fn)
            ole_pkg::FUNC_INS_FRONT, ole_pkg::FUNC_INS_END: begin
              if (count >= CW'(CAPACITY)) status <= ole_pkg::ST_FULL;
              else begin
                anchor <= (fn == ole_pkg::FUNC_INS_FRONT) ? 2'd2 : 2'd1;
                state <= S_FREE;
              end
            end
            ole_pkg::FUNC_INS_AT: begin
              if (pos == '0) status <= ole_pkg::ST_INVALID;
              else if ({1'b0, pos} > 8'(count) + 8'd1) status <= ole_pkg::ST_RANGE;
              else if (count >= CW'(CAPACITY)) status <= ole_pkg::ST_FULL;
              else if (pos == ole_pkg::POS_W'(1)) begin
                anchor <= 2'd2;
                state <= S_FREE;
              end else begin
                anchor <= 2'd0;
                state <= S_WALK;
              end
            end
            ole_pkg::FUNC_DEL_FRONT, ole_pkg::FUNC_DEL_END: begin
              if (count == '0) status <= ole_pkg::ST_EMPTY;
              else state <= S_RDCUR;
            end
            ole_pkg::FUNC_DEL_AT: begin
              if (pos == '0) status <= ole_pkg::ST_INVALID;
              else if (pos == ole_pkg::POS_W'(1) && count == '0) status <= ole_pkg::ST_EMPTY;
              else if ({1'b0, pos} > 8'(count)) status <= ole_pkg::ST_RANGE;
              else state <= S_WALK;
            end
            ole_pkg::FUNC_SEARCH: begin
              status <= ole_pkg::ST_NOT_FOUND;
              state <= S_SRCH;
            end
            default: ;
          endcase
        end
        S_RDCUR: state <= S_DEL;
        S_WALK: begin
          // Cursor reaches position pos-1 for inserts, pos for deletes.
          if ((fn == ole_pkg::FUNC_INS_AT && 8'(steps) + 8'd1 >= {1'b0, pos}) ||
              (fn == ole_pkg::FUNC_DEL_AT && 8'(steps) >= {1'b0, pos})) begin
            state <= (fn == ole_pkg::FUNC_INS_AT) ? S_FREE : S_DEL;
          end else steps <= steps + CW'(1);
        end
        S_SRCH: begin
          if (stat.cur_nil || steps > count) state <= S_DONE;
          else if (stat.match) begin
            status <= ole_pkg::ST_OK;
            found_position <= ole_pkg::POS_W'(steps);
            state <= S_DONE;
          end else steps <= steps + CW'(1);
        end
        S_FREE:   state <= S_INS;
        S_INS:    state <= S_INSFIX;
        S_INSFIX: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DEL:    state <= S_DFIX1;
        S_DFIX1:  state <= S_DFIX2;
        S_DFIX2: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_DONE: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          entry_count <= ole_pkg::POS_W'(count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The cursor value is read at the cursor's new index as it moves, so each
  // walk or search step issues a move and the compare sees the fresh read.
  always_comb begin
    cmd = '0;
    cmd.anchor_tail = (anchor == 2'd1);
    cmd.anchor_nil  = (anchor == 2'd2);
    cmd.sel_tail    = (fn == ole_pkg::FUNC_DEL_END);
    case (state)
      S_INIT:   cmd.op = ole_pkg::OP_INIT;
      S_IDLE:   cmd.op = (s_tvalid && s_tready) ? ole_pkg::OP_LATCH : ole_pkg::OP_NONE;
      S_DECIDE: cmd.op = ole_pkg::OP_START;
      S_RDCUR:  cmd.op = ole_pkg::OP_SET_CUR;
      S_WALK:   cmd.op = ((fn == ole_pkg::FUNC_INS_AT && 8'(steps) + 8'd1 >= {1'b0, pos}) ||
                          (fn == ole_pkg::FUNC_DEL_AT && 8'(steps) >= {1'b0, pos}))
                         ? ole_pkg::OP_NONE : ole_pkg::OP_STEP;
      S_SRCH:   cmd.op = (stat.cur_nil || steps > count || stat.match)
                         ? ole_pkg::OP_NONE : ole_pkg::OP_STEP;
      S_FREE:   cmd.op = ole_pkg::OP_FREE_RD;
      S_INS:    cmd.op = ole_pkg::OP_INS;
      S_INSFIX: cmd.op = ole_pkg::OP_INS_FIX;
      S_DEL:    cmd.op = ole_pkg::OP_DEL;
      S_DFIX1:  cmd.op = ole_pkg::OP_DEL_FIX1;
      S_DFIX2:  cmd.op = ole_pkg::OP_DEL_FIX2;
      default:  cmd.op = ole_pkg::OP_NONE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_INSFIX) |=> count != '0)
    else $error("count zero after insert");
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE)
    else $error("input taken outside idle");

endmodule

@@ rtl/ordered_list_engine_unit.sv @@
// Ordered list engine: a bounded doubly linked list held in entry memory.
// Input channel s_*: tdata = {position, value, func} from the lowest bit:
// func[2:0], value[34:3], position[41:35], zero pad to 48 bits.
// Output channel m_*: tdata = status[2:0], removed_value[34:3],
// found_position[41:35], entry_count[48:42], zero pad to 56 bits.
// Each item yields exactly one result item.
// After reset the free list is chained one entry per cycle, over all CAPACITY
// entries, with s_tready low; then the list is empty.
// Items are handled one at a time. Front and end inserts pass through the
// states S_DECIDE, S_FREE, S_INS, S_INSFIX and S_DONE, front and end deletes
// through S_DECIDE, S_RDCUR, S_DEL, S_DFIX1, S_DFIX2 and S_DONE; positional
// insert, delete and search walk the links one entry per cycle through the
// registered memory read port.
// The result waits in the output register while the receiver stalls. The
// next item is taken no sooner than the cycle after the result has been accepted,
// so the result fields never change while m_tvalid is high.
module ordered_list_engine_unit #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // func, value, position
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status, removed_value, found_position, entry_count
);

  ole_pkg::ole_cmd_t  cmd;
  ole_pkg::ole_stat_t stat;
  logic [2:0]  status;
  logic [31:0] removed_value;
  logic [6:0]  found_position, entry_count;

  ole_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .func(s_tdata[2:0]), .position(s_tdata[41:35]),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .status(status), .found_position(found_position), .entry_count(entry_count),
    .cmd(cmd), .stat(stat)
  );

  ole_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req_value(s_tdata[34:3]),
    .stat(stat), .removed_value(removed_value)
  );

  assign m_tdata = {7'd0, entry_count, found_position, removed_value, status};

endmodule
